// ===== src/istag_pkg.sv =====
`timescale 1ns / 1ps
// Package for the inline style tagger: character codes, the job record that
// passes from decode to emit, and the tag byte helpers. No dependencies.
package istag_pkg;

   // Character codes
   localparam logic [7:0] CH_STAR   = 8'h2A;  // '*'
   localparam logic [7:0] CH_BTICK  = 8'h60;  // '`'
   localparam logic [7:0] CH_LBRACK = 8'h5B;  // '['
   localparam logic [7:0] CH_RBRACK = 8'h5D;  // ']'
   localparam logic [7:0] CH_BSLASH = 8'h5C;  // '\'
   localparam logic [7:0] CH_BAR    = 8'h7C;  // '|'
   localparam logic [7:0] CH_ZERO   = 8'h30;  // '0'
   localparam logic [7:0] CH_ONE    = 8'h31;  // '1'

   // Style set: bit 0 bold, bit 1 italic, bit 2 code
   typedef logic [2:0] style_type;

   // Output work for one input item, in emission order:
   // first tag, escape, literal byte, second tag, closing reset tag
   typedef struct packed {
      logic      t1_en;
      style_type t1_sty;
      logic      esc_en;
      logic      chr_en;
      logic [7:0] chr;
      logic      t2_en;
      style_type t2_sty;
      logic      end_en;
      logic      last;
   } job_type;

   // Segments of a job
   typedef enum logic [2:0] {
      SEG_TAG1 = 3'd0,
      SEG_ESC  = 3'd1,
      SEG_CHAR = 3'd2,
      SEG_TAG2 = 3'd3,
      SEG_END  = 3'd4
   } seg_type;

   // Byte at position pos of the tag pair "[00]" + "[0a|0b..]" for a style set
   function automatic logic [7:0] tag_byte(input style_type sty, input logic [3:0] pos);
      logic [7:0] seq [16];
      logic [3:0] n;
      for (int k = 0; k < 16; k++) seq[k] = 8'h00;
      seq[0] = CH_LBRACK;
      seq[1] = CH_ZERO;
      seq[2] = CH_ZERO;
      seq[3] = CH_RBRACK;
      seq[4] = CH_LBRACK;
      n = 4'd5;
      for (int k = 0; k < 3; k++) begin
         if (sty[k]) begin
            if (n != 4'd5) begin
               seq[n] = CH_BAR;
               n = n + 4'd1;
            end
            seq[n] = CH_ZERO;
            seq[n + 4'd1] = CH_ONE + 8'(k);
            n = n + 4'd2;
         end
      end
      seq[n] = CH_RBRACK;
      return seq[pos];
   endfunction

   // Number of bytes in the tag output for a style set
   function automatic logic [3:0] tag_len(input style_type sty);
      logic [1:0] cnt;
      cnt = 2'(sty[0]) + 2'(sty[1]) + 2'(sty[2]);
      case (cnt)
         2'd0:    return 4'd4;
         2'd1:    return 4'd8;
         2'd2:    return 4'd11;
         default: return 4'd14;
      endcase
   endfunction

endpackage

// ===== src/istag_if.sv =====
`timescale 1ns / 1ps
// Channel interfaces for the inline style tagger: raw byte input and tagged
// byte output, each a valid/ready handshake. No dependencies.
interface istag_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       in_last;
   modport source (output valid, output in_byte, output in_last, input ready);
   modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface istag_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       run_end;
   logic       line_end;
   modport source (output valid, output out_byte, output run_end, output line_end,
                   input ready);
   modport sink   (input valid, input out_byte, input run_end, input line_end,
                   output ready);
endinterface

// ===== src/istag_decode.sv =====
`timescale 1ns / 1ps
// Decode stage: holds the style state and the held star, and turns each
// accepted byte into a job record. Depends on istag_pkg.
module istag_decode (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  logic [7:0]        in_byte,
   input  logic              in_last,
   output istag_pkg::job_type job,
   output logic              job_any
);

   logic bold_ff, italic_ff, code_ff, held_ff;
   logic bold_in, italic_in, code_in, held_in;

   // Next style state and job contents
   always_comb begin
      logic b, i, c;
      b = bold_ff;
      i = italic_ff;
      c = code_ff;
      held_in = held_ff;
      job = '0;
      job.chr  = in_byte;
      job.last = in_last;

      if (held_ff) begin
         held_in = 1'b0;
         if (in_byte == istag_pkg::CH_STAR) begin
            b = !b;
            job.t1_en  = 1'b1;
            job.t1_sty = {c, i, b};
         end else begin
            i = !i;
            job.t1_en  = 1'b1;
            job.t1_sty = {c, i, b};
            if (in_byte == istag_pkg::CH_BTICK) begin
               c = !c;
               job.t2_en  = 1'b1;
               job.t2_sty = {c, i, b};
            end else begin
               job.esc_en = (in_byte == istag_pkg::CH_LBRACK);
               job.chr_en = 1'b1;
            end
         end
      end else if (in_byte == istag_pkg::CH_STAR) begin
         if (in_last) begin
            i = !i;
            job.t1_en  = 1'b1;
            job.t1_sty = {c, i, b};
         end else begin
            held_in = 1'b1;
         end
      end else if (in_byte == istag_pkg::CH_BTICK) begin
         c = !c;
         job.t2_en  = 1'b1;
         job.t2_sty = {c, i, b};
      end else begin
         job.esc_en = (in_byte == istag_pkg::CH_LBRACK);
         job.chr_en = 1'b1;
      end

      // Close any open style at end of line, then start the next line clean
      job.end_en = in_last && (b || i || c);
      if (in_last) begin
         b = 1'b0;
         i = 1'b0;
         c = 1'b0;
         held_in = 1'b0;
      end
      bold_in   = b;
      italic_in = i;
      code_in   = c;
   end

   assign job_any = job.t1_en || job.esc_en || job.chr_en || job.t2_en || job.end_en;

   // Style state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         bold_ff   <= 1'b0;
         italic_ff <= 1'b0;
         code_ff   <= 1'b0;
         held_ff   <= 1'b0;
      end else if (accept) begin
         bold_ff   <= bold_in;
         italic_ff <= italic_in;
         code_ff   <= code_in;
         held_ff   <= held_in;
      end
   end

endmodule

// ===== src/istag_emit.sv =====
`timescale 1ns / 1ps
// Emit stage: job register, segment/position sequencer and the output register that
// drives one tagged byte per cycle unless rsp_ch stalls. Depends on istag_pkg, istag_if.
module istag_emit (
   input  logic              clock,
   input  logic              reset,
   input  logic              load,
   input  istag_pkg::job_type job_in,
   output logic              ready,
   istag_rsp_if.source       rsp_ch
);

   istag_pkg::job_type job_ff;
   logic               job_vld_ff;
   istag_pkg::seg_type seg_ff;
   logic [3:0]         pos_ff;

   logic               rsp_vld_ff;
   logic [7:0]         byte_ff;
   logic               run_end_ff, line_end_ff;

   logic [4:0]         seg_on, seg_on_in;
   istag_pkg::seg_type nxt_seg, first_seg;
   logic               nxt_found;
   logic [7:0]         cur_byte;
   logic [3:0]         cur_len;
   logic               seg_last, job_last_byte, out_free, step, finish;

   assign seg_on    = {job_ff.end_en, job_ff.t2_en, job_ff.chr_en, job_ff.esc_en,
                       job_ff.t1_en};
   assign seg_on_in = {job_in.end_en, job_in.t2_en, job_in.chr_en, job_in.esc_en,
                       job_in.t1_en};

   // First segment of a new job, next segment of the current one
   always_comb begin
      first_seg = istag_pkg::SEG_TAG1;
      nxt_seg   = istag_pkg::SEG_TAG1;
      nxt_found = 1'b0;
      for (int k = 4; k >= 0; k--) begin
         if (seg_on_in[k]) first_seg = istag_pkg::seg_type'(k[2:0]);
         if (k > int'(seg_ff) && seg_on[k]) begin
            nxt_seg   = istag_pkg::seg_type'(k[2:0]);
            nxt_found = 1'b1;
         end
      end
   end

   // Byte and length of the current segment
   always_comb begin
      unique case (seg_ff)
         istag_pkg::SEG_TAG1: begin
            cur_byte = istag_pkg::tag_byte(job_ff.t1_sty, pos_ff);
            cur_len  = istag_pkg::tag_len(job_ff.t1_sty);
         end
         istag_pkg::SEG_ESC: begin
            cur_byte = istag_pkg::CH_BSLASH;
            cur_len  = 4'd1;
         end
         istag_pkg::SEG_CHAR: begin
            cur_byte = job_ff.chr;
            cur_len  = 4'd1;
         end
         istag_pkg::SEG_TAG2: begin
            cur_byte = istag_pkg::tag_byte(job_ff.t2_sty, pos_ff);
            cur_len  = istag_pkg::tag_len(job_ff.t2_sty);
         end
         default: begin
            cur_byte = istag_pkg::tag_byte(3'b000, pos_ff);
            cur_len  = 4'd4;
         end
      endcase
   end

   assign seg_last      = (pos_ff == cur_len - 4'd1);
   assign job_last_byte = seg_last && !nxt_found;
   assign out_free      = !rsp_vld_ff || rsp_ch.ready;
   assign step          = job_vld_ff && out_free;
   assign finish        = step && job_last_byte;
   assign ready         = !job_vld_ff || finish;

   // Job register and sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         job_vld_ff <= 1'b0;
         seg_ff     <= istag_pkg::SEG_TAG1;
         pos_ff     <= 4'd0;
      end else if (load) begin
         job_vld_ff <= 1'b1;
         seg_ff     <= first_seg;
         pos_ff     <= 4'd0;
      end else if (finish) begin
         job_vld_ff <= 1'b0;
      end else if (step) begin
         if (seg_last) begin
            seg_ff <= nxt_seg;
            pos_ff <= 4'd0;
         end else begin
            pos_ff <= pos_ff + 4'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) job_ff <= job_in;
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (step) begin
         rsp_vld_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         byte_ff     <= cur_byte;
         run_end_ff  <= job_last_byte;
         line_end_ff <= job_last_byte && job_ff.last;
      end
   end

   assign rsp_ch.valid    = rsp_vld_ff;
   assign rsp_ch.out_byte = byte_ff;
   assign rsp_ch.run_end  = run_end_ff;
   assign rsp_ch.line_end = line_end_ff;

endmodule

// ===== src/inline_markup_style_tagger_core.sv =====
`timescale 1ns / 1ps
// Top level of the inline style tagger: decode stage plus emit stage.
// Depends on istag_pkg, istag_if, istag_decode, istag_emit.
//
//   channel  dir  handshake          payload
//   req_ch   in   valid/ready        in_byte[7:0], in_last
//   rsp_ch   out  valid/ready        out_byte[7:0], run_end, line_end
//
// One tagged byte leaves per cycle unless rsp_ch stalls; an input item that yields
// N bytes holds the input until the last of them enters the single-byte output register.
// An item yielding one byte or none is taken every cycle unless rsp_ch stalls.
// A new item is taken while the last byte of the previous one waits on rsp_ch.
// Reset is synchronous and clears style state, the job and the output valid.
module inline_markup_style_tagger_core (
   input  logic         clock,
   input  logic         reset,
   istag_req_if.sink    req_ch,
   istag_rsp_if.source  rsp_ch
);

   istag_pkg::job_type job;
   logic               job_any;
   logic               ready;
   logic               fire;

   assign req_ch.ready = ready;
   assign fire         = req_ch.valid && ready;

   istag_decode u_decode (
      .clock   (clock),
      .reset   (reset),
      .accept  (fire),
      .in_byte (req_ch.in_byte),
      .in_last (req_ch.in_last),
      .job     (job),
      .job_any (job_any)
   );

   istag_emit u_emit (
      .clock  (clock),
      .reset  (reset),
      .load   (fire && job_any),
      .job_in (job),
      .ready  (ready),
      .rsp_ch (rsp_ch)
   );

endmodule
